// ===== rtl/kplt_pkg.sv =====
// ----------------------------------------------------------------------------
// kplt_pkg
// Shared types and constants for the key press latch table.
// ----------------------------------------------------------------------------
package kplt_pkg;

   localparam int KEY_COUNT_DEF  = 256;
   localparam int COUNT_BITS_DEF = 16;
   localparam int CODE_BITS      = 8;
   localparam int OPCODE_BITS    = 3;
   localparam int TAKEN_BITS     = 16;
   localparam int TOTAL_BITS     = 32;

   // keys 1..6 except 3 always count a press
   localparam logic [CODE_BITS-1:0] AC_FIRST = CODE_BITS'(1);
   localparam logic [CODE_BITS-1:0] AC_LAST  = CODE_BITS'(6);
   localparam logic [CODE_BITS-1:0] AC_SKIP  = CODE_BITS'(3);

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_PRESS   = 3'd0,
      OP_RELEASE = 3'd1,
      OP_TAKE    = 3'd2,
      OP_TOTAL   = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [CODE_BITS-1:0]   key_code;
      logic                   physically_held;
   } req_type;

   typedef struct packed {
      logic                  newly_pressed;
      logic [TAKEN_BITS-1:0] taken_count;
      logic                  hold_started;
      logic [TOTAL_BITS-1:0] press_total;
   } rsp_type;

   function automatic logic always_counts(input logic [CODE_BITS-1:0] code);
      return (code >= AC_FIRST) && (code <= AC_LAST) && (code != AC_SKIP);
   endfunction

endpackage

// ===== rtl/kplt_table.sv =====
// ----------------------------------------------------------------------------
// kplt_table
// Entry store with separate read and write ports, registered read and per-entry valid bits;
// an entry that is not valid reads as all zero.
// ----------------------------------------------------------------------------
module kplt_table import kplt_pkg::*; #(
   parameter int KEY_COUNT  = KEY_COUNT_DEF,
   parameter int ENTRY_BITS = COUNT_BITS_DEF + TOTAL_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(KEY_COUNT)-1:0] rd_addr,
   output logic [ENTRY_BITS-1:0]        rd_entry,
   input  logic                         wr_en,
   input  logic [$clog2(KEY_COUNT)-1:0] wr_addr,
   input  logic [ENTRY_BITS-1:0]        wr_entry,
   input  logic                         clear_all
);

   logic [ENTRY_BITS-1:0] mem [KEY_COUNT];
   logic [KEY_COUNT-1:0]  valid_ff;
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (clear_all) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/key_press_latch_table_core.sv =====
// ----------------------------------------------------------------------------
// key_press_latch_table_core
// Key event latch: press, release, take, read total and clear-all over a
// table of per-key entries held in one synchronous memory.
// ----------------------------------------------------------------------------
// The table is read when a request is accepted; the response is registered when
// the request finishes, which waits while the previous response is not yet taken.
// A new request is taken only after the previous one has finished the read then
// write-back of the table.
// Reset and clear-all empty the table through per-entry valid bits; no clearing
// sweep, requests are taken straight after reset.
module key_press_latch_table_core import kplt_pkg::*; #(
   parameter int KEY_COUNT  = KEY_COUNT_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int ADDR_BITS  = $clog2(KEY_COUNT);
   localparam int ENTRY_BITS = COUNT_BITS + TOTAL_BITS + 2;

   typedef struct packed {
      logic                  down;
      logic                  hold;
      logic [COUNT_BITS-1:0] pending;
      logic [TOTAL_BITS-1:0] total;
   } entry_type;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic      in_range_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff;

   logic      accept;
   logic      finish;
   entry_type ent_rd, ent_wr;
   logic      wr_en;
   logic      clear_all;
   logic      ac;
   logic [COUNT_BITS+TAKEN_BITS-1:0] pend_wide;

   // ---------------- state machine
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: finish    = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            finish    = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_payload;
         in_range_ff <= {1'b0, req_payload.key_code} < (CODE_BITS+1)'(KEY_COUNT);
      end
   end

   // ---------------- table
   kplt_table #(
      .KEY_COUNT  (KEY_COUNT),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (req_payload.key_code[ADDR_BITS-1:0]),
      .rd_entry  (ent_rd),
      .wr_en     (wr_en),
      .wr_addr   (req_ff.key_code[ADDR_BITS-1:0]),
      .wr_entry  (ent_wr),
      .clear_all (clear_all)
   );

   // ---------------- read-modify-write
   assign ac        = always_counts(req_ff.key_code);
   assign pend_wide = {TAKEN_BITS'(0), ent_rd.pending};

   always_comb begin
      ent_wr    = ent_rd;
      rsp_in    = '0;
      wr_en     = 1'b0;
      clear_all = 1'b0;
      case (req_ff.opcode)
         OP_PRESS: begin
            if (in_range_ff) begin
               rsp_in.newly_pressed = !ent_rd.down;
               if (ac) begin
                  ent_wr.hold = 1'b0;
               end
               if (ac || !ent_rd.down) begin
                  if (ent_rd.pending != '1) begin
                     ent_wr.pending = ent_rd.pending + COUNT_BITS'(1);
                  end
                  ent_wr.total = ent_rd.total + TOTAL_BITS'(1);
               end
               ent_wr.down = 1'b1;
               wr_en       = finish;
            end
         end
         OP_RELEASE: begin
            if (in_range_ff) begin
               ent_wr.down = 1'b0;
               ent_wr.hold = 1'b0;
               wr_en       = finish;
            end
         end
         OP_TAKE: begin
            if (in_range_ff) begin
               // a missed release ends the hold first
               if (ent_rd.down && !req_ff.physically_held) begin
                  ent_wr.down = 1'b0;
                  ent_wr.hold = 1'b0;
               end
               rsp_in.taken_count = pend_wide[TAKEN_BITS-1:0];
               if (ent_wr.down && !ent_wr.hold) begin
                  rsp_in.hold_started = 1'b1;
                  ent_wr.hold         = 1'b1;
               end
               ent_wr.pending = '0;
               wr_en          = finish;
            end
         end
         OP_TOTAL: begin
            if (in_range_ff) begin
               rsp_in.press_total = ent_rd.total;
            end
         end
         OP_CLEAR: clear_all = finish;
         default: rsp_in = '0;
      endcase
   end

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_press_latch_table_core. A queue-fed driver
// offers requests, and a shadow copy of the key table predicts every response.
// A monitor compares each response with the oldest prediction. The run covers
// directed corner cases, random request mixes with idle gaps and back-pressure,
// and a short press burst on an always-count key.
// ----------------------------------------------------------------------------
module testbench import kplt_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEYS          = 256;
   localparam int CYCLE_LIMIT   = 200_000;
   localparam int BURST_PRESSES = 16;
   localparam int HOLDOFF_LEN   = 400;

   // opcodes the block has no meaning for
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_BITS-1:0] OP_SPARE_LAST  = 3'd7;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   key_press_latch_table_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow key table
   logic                  down_flag      [KEYS];
   logic                  hold_flag      [KEYS];
   logic [TAKEN_BITS-1:0] press_pending  [KEYS];
   logic [TOTAL_BITS-1:0] press_lifetime [KEYS];

   req_type key_event_q[$];
   rsp_type expected_rsp_q[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  send_gap       = 0;
   int  recv_gap       = 0;
   bit  gaps_on        = 1'b1;
   bit  random_started = 1'b0;
   logic rsp_holdoff   = 1'b0;

   function automatic void wipe_table();
      for (int i = 0; i < KEYS; i++) begin
         down_flag[i]      = 1'b0;
         hold_flag[i]      = 1'b0;
         press_pending[i]  = '0;
         press_lifetime[i] = '0;
      end
   endfunction

   function automatic rsp_type latch_table_predict(req_type r);
      rsp_type res;
      int      k;
      bit      forced;
      res    = '0;
      k      = int'(r.key_code);
      // keys 1, 2, 4, 5 and 6 count every press and re-arm the hold report
      forced = (k >= 1) && (k <= 6) && (k != 3);
      case (r.opcode)
         OP_CLEAR: wipe_table();
         OP_PRESS: begin
            res.newly_pressed = !down_flag[k];
            if (forced)
               hold_flag[k] = 1'b0;
            if (forced || !down_flag[k]) begin
               if (press_pending[k] != '1)
                  press_pending[k] = press_pending[k] + TAKEN_BITS'(1);
               press_lifetime[k] = press_lifetime[k] + TOTAL_BITS'(1);
            end
            down_flag[k] = 1'b1;
         end
         OP_RELEASE: begin
            down_flag[k] = 1'b0;
            hold_flag[k] = 1'b0;
         end
         OP_TAKE: begin
            // release that was never seen
            if (down_flag[k] && !r.physically_held) begin
               down_flag[k] = 1'b0;
               hold_flag[k] = 1'b0;
            end
            res.taken_count = press_pending[k];
            if (down_flag[k] && !hold_flag[k]) begin
               res.hold_started = 1'b1;
               hold_flag[k]     = 1'b1;
            end
            press_pending[k] = '0;
         end
         OP_TOTAL: res.press_total = press_lifetime[k];
         default: ;
      endcase
      return res;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(latch_table_predict(req_payload));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (key_event_q.size() > 0) begin
               req_payload <= key_event_q.pop_front();
               req_valid   <= 1'b1;
               send_gap    = draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected response %h", rsp_payload);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_payload.newly_pressed !== want.newly_pressed ||
                   rsp_payload.taken_count   !== want.taken_count ||
                   rsp_payload.hold_started  !== want.hold_started ||
                   rsp_payload.press_total   !== want.press_total) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"ERROR: response mismatch: newly_pressed %0b/%0b ",
                               "taken_count %0d/%0d hold_started %0b/%0b ",
                               "press_total %0d/%0d (expected/actual)"},
                              want.newly_pressed, rsp_payload.newly_pressed,
                              want.taken_count, rsp_payload.taken_count,
                              want.hold_started, rsp_payload.hold_started,
                              want.press_total, rsp_payload.press_total);
               end
            end
         end
         if (rsp_holdoff) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap  = draw_gap();
         end
      end
   end

   // long receiver hold-off early in the random part; the table backs up
   initial begin
      while (!random_started)
         @(posedge clock);
      repeat (20) @(posedge clock);
      rsp_holdoff <= 1'b1;
      repeat (HOLDOFF_LEN) @(posedge clock);
      rsp_holdoff <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("key_press_latch_table_core verification failed");
         $finish;
      end
   end

   task automatic queue_request(logic [OPCODE_BITS-1:0] op, logic [CODE_BITS-1:0] key,
                                logic held);
      req_type r;
      r.opcode          = op;
      r.key_code        = key;
      r.physically_held = held;
      key_event_q.push_back(r);
   endtask

   task automatic wait_drained();
      while (key_event_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_random_request();
      logic [CODE_BITS-1:0]   key;
      logic [OPCODE_BITS-1:0] op;
      int                     r;
      r = $urandom_range(0, 99);
      // mostly a few hot keys, so presses, takes and releases interact
      if (r < 60)
         key = CODE_BITS'($urandom_range(0, 8));
      else if (r < 75)
         key = CODE_BITS'($urandom_range(8'hC1, 8'hC4));
      else if (r < 80)
         key = 8'hFF;
      else
         key = CODE_BITS'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 36)
         op = OP_PRESS;
      else if (r < 55)
         op = OP_RELEASE;
      else if (r < 84)
         op = OP_TAKE;
      else if (r < 96)
         op = OP_TOTAL;
      else if (r < 98)
         op = OP_CLEAR;
      else
         op = OPCODE_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      queue_request(op, key, 1'($urandom_range(0, 1)));
   endtask

   initial begin
      wipe_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      queue_request(OP_PRESS, 8'd0, 1'b1);
      queue_request(OP_PRESS, 8'd0, 1'b1);      // already down: no count
      queue_request(OP_TOTAL, 8'd0, 1'b0);
      queue_request(OP_TAKE, 8'd0, 1'b1);       // hold starts
      queue_request(OP_TAKE, 8'd0, 1'b1);       // hold already reported
      queue_request(OP_TAKE, 8'd0, 1'b0);       // missed release
      queue_request(OP_PRESS, 8'd5, 1'b1);
      queue_request(OP_PRESS, 8'd5, 1'b1);      // always-count key
      queue_request(OP_TAKE, 8'd5, 1'b1);
      queue_request(OP_PRESS, 8'd5, 1'b1);      // re-arms hold
      queue_request(OP_TAKE, 8'd5, 1'b1);
      queue_request(OP_PRESS, 8'd3, 1'b1);
      queue_request(OP_PRESS, 8'd3, 1'b1);      // 3 is not always-count
      queue_request(OP_TOTAL, 8'd3, 1'b1);
      queue_request(OP_PRESS, 8'hFF, 1'b1);
      queue_request(OP_PRESS, 8'hC1, 1'b0);     // composite codes are plain keys
      queue_request(OP_RELEASE, 8'hFF, 1'b1);
      queue_request(OP_TAKE, 8'hFF, 1'b1);
      queue_request(OP_TOTAL, 8'hFF, 1'b0);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         queue_request(OPCODE_BITS'(op), 8'hFF, 1'b1);
      queue_request(OP_CLEAR, 8'hAA, 1'b1);
      queue_request(OP_TOTAL, 8'd5, 1'b0);
      queue_request(OP_TAKE, 8'hC1, 1'b1);
      wait_drained();

      // random mix in chunks, with and without idling
      random_started = 1'b1;
      for (int chunk = 0; chunk < 7; chunk++) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 50; i++)
            queue_random_request();
         // sender pause until everything has come back
         if (chunk == 3)
            wait_drained();
      end
      wait_drained();

      // press burst on an always-count key, then take and read back
      gaps_on = 1'b0;
      queue_request(OP_CLEAR, 8'd0, 1'b0);
      for (int i = 0; i < BURST_PRESSES; i++)
         queue_request(OP_PRESS, 8'd2, 1'b1);
      queue_request(OP_TAKE, 8'd2, 1'b1);
      queue_request(OP_TOTAL, 8'd2, 1'b1);
      queue_request(OP_TAKE, 8'd2, 1'b1);
      wait_drained();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("key_press_latch_table_core verification clean");
      else
         $display("key_press_latch_table_core verification failed");
      $finish;
   end

endmodule

// ===== key_press_latch_table_core.f =====
rtl/kplt_pkg.sv
rtl/kplt_table.sv
rtl/key_press_latch_table_core.sv
bench/testbench.sv
